// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define BCC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("bcc assertion failed");

// condition that must never be true outside reset
`define BCC_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("bcc forbidden condition seen");

`endif

// ===== hdl/bcc_pkg.sv =====
package bcc_pkg;

    typedef enum logic [1:0] {
        CMD_SCAN     = 2'd0,
        CMD_WAKE     = 2'd1,
        CMD_POWER_ON = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_SCAN_ENABLE   = 2'd0,
        REG_DEBOUNCE_MS   = 2'd1,
        REG_LONG_PRESS_MS = 2'd2,
        REG_COMBO_GAP_MS  = 2'd3
    } reg_idx_t;

    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_LONG   = 3'd5;
    localparam logic [2:0] CLICK_MAX = 3'd4;

    localparam logic [15:0] DEBOUNCE_RST   = 16'd40;
    localparam logic [15:0] LONG_PRESS_RST = 16'd3000;
    localparam logic [15:0] COMBO_GAP_RST  = 16'd500;

    typedef struct packed {
        logic        scan_enable;
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] combo_gap_ms;
    } cfg_t;

endpackage

// ===== hdl/bcc_cfg.sv =====
module bcc_cfg
    import bcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    logic     wr_en;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scan_enable   <= 1'b0;
            cfg_reg.debounce_ms   <= DEBOUNCE_RST;
            cfg_reg.long_press_ms <= LONG_PRESS_RST;
            cfg_reg.combo_gap_ms  <= COMBO_GAP_RST;
        end else if (wr_en) begin
            unique case (idx)
                REG_SCAN_ENABLE:   cfg_reg.scan_enable   <= pwdata[0];
                REG_DEBOUNCE_MS:   cfg_reg.debounce_ms   <= pwdata[15:0];
                REG_LONG_PRESS_MS: cfg_reg.long_press_ms <= pwdata[15:0];
                REG_COMBO_GAP_MS:  cfg_reg.combo_gap_ms  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SCAN_ENABLE:   prdata = {31'd0, cfg_reg.scan_enable};
            REG_DEBOUNCE_MS:   prdata = {16'd0, cfg_reg.debounce_ms};
            REG_LONG_PRESS_MS: prdata = {16'd0, cfg_reg.long_press_ms};
            REG_COMBO_GAP_MS:  prdata = {16'd0, cfg_reg.combo_gap_ms};
            default:           prdata = 32'd0;
        endcase
    end

endmodule

// ===== hdl/bcc_core.sv =====
`include "assert_macros.svh"

module bcc_core
    import bcc_pkg::*;
#(
    parameter int TIME_BITS = 16
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        fire,
    input  logic [1:0]  cmd,
    input  logic        level,
    input  logic [15:0] now,
    input  cfg_t        cfg,
    output logic [2:0]  event_res
);

    localparam int CW = (TIME_BITS > 16) ? TIME_BITS : 16;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HELD  = 2'd1,
        PH_COMBO = 2'd2
    } phase_t;

    phase_t               phase_reg, phase_next;
    logic                 last_raw_reg, last_raw_next;
    logic                 stable_reg, stable_next;
    logic [2:0]           click_reg, click_next;
    logic                 long_rep_reg, long_rep_next;
    logic [TIME_BITS-1:0] edge_time_reg, edge_time_next;
    logic [TIME_BITS-1:0] press_time_reg, press_time_next;
    logic [TIME_BITS-1:0] release_time_reg, release_time_next;

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] el_edge, el_press, el_release;
    logic [2:0]           ev;

    assign now_t     = TIME_BITS'(now);
    assign event_res = ev;

    always_comb begin
        phase_next        = phase_reg;
        last_raw_next     = last_raw_reg;
        stable_next       = stable_reg;
        click_next        = click_reg;
        long_rep_next     = long_rep_reg;
        edge_time_next    = edge_time_reg;
        press_time_next   = press_time_reg;
        release_time_next = release_time_reg;
        ev                = EV_NONE;
        el_edge           = '0;
        el_press          = '0;
        el_release        = '0;
        case (cmd_t'(cmd))
            CMD_WAKE, CMD_POWER_ON: begin
                edge_time_next = now_t;
                last_raw_next  = level;
                stable_next    = level;
                click_next     = 3'd0;
                if (!level) begin
                    phase_next      = PH_HELD;
                    long_rep_next   = (cmd_t'(cmd) == CMD_POWER_ON);
                    press_time_next = now_t;
                end else begin
                    phase_next    = PH_IDLE;
                    long_rep_next = 1'b0;
                end
            end
            CMD_SCAN: begin
                if (cfg.scan_enable) begin
                    if (level != last_raw_reg) begin
                        last_raw_next  = level;
                        edge_time_next = now_t;
                    end
                    el_edge = now_t - edge_time_next;
                    if (CW'(el_edge) >= CW'(cfg.debounce_ms) && level != stable_reg) begin
                        stable_next = level;
                        if (!level) begin
                            press_time_next = now_t;
                            long_rep_next   = 1'b0;
                            phase_next      = PH_HELD;
                        end else if (long_rep_reg) begin
                            long_rep_next = 1'b0;
                            click_next    = 3'd0;
                            phase_next    = PH_IDLE;
                        end else begin
                            if (click_reg < CLICK_MAX) begin
                                click_next = click_reg + 3'd1;
                            end
                            release_time_next = now_t;
                            phase_next        = PH_COMBO;
                        end
                    end
                    el_press   = now_t - press_time_next;
                    el_release = now_t - release_time_next;
                    if (phase_next == PH_HELD && !long_rep_next
                        && CW'(el_press) >= CW'(cfg.long_press_ms)) begin
                        long_rep_next = 1'b1;
                        ev            = EV_LONG;
                    end
                    if (phase_next == PH_COMBO
                        && CW'(el_release) >= CW'(cfg.combo_gap_ms)) begin
                        ev         = click_next;
                        click_next = 3'd0;
                        phase_next = PH_IDLE;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            last_raw_reg     <= 1'b1;
            stable_reg       <= 1'b1;
            click_reg        <= 3'd0;
            long_rep_reg     <= 1'b0;
            edge_time_reg    <= '0;
            press_time_reg   <= '0;
            release_time_reg <= '0;
        end else if (fire) begin
            phase_reg        <= phase_next;
            last_raw_reg     <= last_raw_next;
            stable_reg       <= stable_next;
            click_reg        <= click_next;
            long_rep_reg     <= long_rep_next;
            edge_time_reg    <= edge_time_next;
            press_time_reg   <= press_time_next;
            release_time_reg <= release_time_next;
        end
    end

    `BCC_ASSERT(a_click_sat, aclk, aresetn, click_reg <= CLICK_MAX)
    `BCC_NEVER(a_idle_no_clicks, aclk, aresetn, phase_reg == PH_IDLE && click_reg != 3'd0)
    `BCC_ASSERT(a_long_marks, aclk, aresetn, fire && ev == EV_LONG |=> long_rep_reg)

endmodule

// ===== hdl/button_click_classifier.sv =====
// Button click classifier. Each item is one pin sample (or resync command)
// with a millisecond tick; each item yields exactly one result item whose
// event_res is 0 (nothing), 1..4 (single to quad click) or 5 (long press).
// One item is taken every clock while the output is not stalled: the item
// goes into an input register, the debounce and click logic runs
// combinationally up to the result register, and the result is offered from
// that register. The user writes registers over the APB port only while no
// items are in flight; the block itself does not enforce this.
`include "assert_macros.svh"

module button_click_classifier
    import bcc_pkg::*;
#(
    parameter int TIME_BITS = 16
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic        s_level,
    input  logic [15:0] s_now,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t        cfg;
    logic        in_valid_reg;
    logic [1:0]  cmd_reg;
    logic        level_reg;
    logic [15:0] now_reg;
    logic        out_valid_reg;
    logic [2:0]  event_reg;
    logic [2:0]  event_next;
    logic        fire;

    assign fire        = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready     = !in_valid_reg || fire;
    assign m_valid     = out_valid_reg;
    assign m_event_res = event_reg;

    bcc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bcc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .cmd       (cmd_reg),
        .level     (level_reg),
        .now       (now_reg),
        .cfg       (cfg),
        .event_res (event_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            cmd_reg   <= s_cmd;
            level_reg <= s_level;
            now_reg   <= s_now;
        end
        if (fire) begin
            event_reg <= event_next;
        end
    end

    `BCC_ASSERT(a_fire_to_out, aclk, aresetn, fire |=> m_valid)
    `BCC_ASSERT(a_event_range, aclk, aresetn, m_valid |-> m_event_res <= EV_LONG)
    `BCC_NEVER(a_no_overrun, aclk, aresetn, fire && out_valid_reg && !m_ready)

endmodule

// ===== tb/click_event_checker.sv =====
module click_event_checker
    import bcc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic        s_level,
    input  logic [15:0] s_now,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_event_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatch_count,
    output int          events_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HELD,
        PH_COMBO
    } press_phase_t;

    cfg_t         cfg;
    logic         raw_q;
    logic         stable_q;
    logic         long_done;
    press_phase_t phase;
    logic [2:0]   clicks;
    logic [15:0]  edge_t;
    logic [15:0]  press_t;
    logic [15:0]  release_t;
    logic [2:0]   expected_events[$];

    function automatic logic [2:0] classify_sample(input logic [1:0] cmd, input logic lvl,
                                                   input logic [15:0] now);
        logic [2:0]  ev;
        logic [15:0] since_edge;
        logic [15:0] since_press;
        logic [15:0] since_release;
        ev = EV_NONE;
        if (cmd == CMD_WAKE || cmd == CMD_POWER_ON) begin
            raw_q    = lvl;
            stable_q = lvl;
            edge_t   = now;
            clicks   = '0;
            if (lvl == 1'b0) begin
                phase     = PH_HELD;
                press_t   = now;
                long_done = (cmd == CMD_POWER_ON);
            end else begin
                phase     = PH_IDLE;
                long_done = 1'b0;
            end
        end else if (cmd == CMD_SCAN && cfg.scan_enable) begin
            if (lvl != raw_q) begin
                raw_q  = lvl;
                edge_t = now;
            end
            since_edge = now - edge_t;
            if (since_edge >= cfg.debounce_ms && lvl != stable_q) begin
                stable_q = lvl;
                if (lvl == 1'b0) begin
                    press_t   = now;
                    long_done = 1'b0;
                    phase     = PH_HELD;
                end else if (long_done) begin
                    // release that ends a long press is not a click
                    long_done = 1'b0;
                    clicks    = '0;
                    phase     = PH_IDLE;
                end else begin
                    if (clicks < CLICK_MAX) begin
                        clicks = clicks + 3'd1;
                    end
                    release_t = now;
                    phase     = PH_COMBO;
                end
            end
            since_press = now - press_t;
            if (phase == PH_HELD && !long_done && since_press >= cfg.long_press_ms) begin
                long_done = 1'b1;
                ev        = EV_LONG;
            end
            since_release = now - release_t;
            if (phase == PH_COMBO && since_release >= cfg.combo_gap_ms) begin
                ev     = clicks;
                clicks = '0;
                phase  = PH_IDLE;
            end
        end
        return ev;
    endfunction

    always @(posedge aclk) begin : monitor
        logic [2:0] want;
        if (!aresetn) begin
            cfg.scan_enable   = 1'b0;
            cfg.debounce_ms   = DEBOUNCE_RST;
            cfg.long_press_ms = LONG_PRESS_RST;
            cfg.combo_gap_ms  = COMBO_GAP_RST;
            raw_q             = 1'b1;
            stable_q          = 1'b1;
            long_done         = 1'b0;
            phase             = PH_IDLE;
            clicks            = '0;
            edge_t            = '0;
            press_t           = '0;
            release_t         = '0;
            expected_events.delete();
            mismatch_count    = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_SCAN_ENABLE:   cfg.scan_enable   = pwdata[0];
                    REG_DEBOUNCE_MS:   cfg.debounce_ms   = pwdata[15:0];
                    REG_LONG_PRESS_MS: cfg.long_press_ms = pwdata[15:0];
                    REG_COMBO_GAP_MS:  cfg.combo_gap_ms  = pwdata[15:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    $error("event_res: unexpected item, expected none, actual %0d",
                           m_event_res);
                    mismatch_count++;
                end else begin
                    want = expected_events.pop_front();
                    if (m_event_res !== want) begin
                        $error("event_res mismatch: expected %0d, actual %0d",
                               want, m_event_res);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_events.push_back(classify_sample(s_cmd, s_level, s_now));
            end
        end
        events_pending = expected_events.size();
    end

endmodule

// ===== tb/tb_button_click_classifier.sv =====
module tb_button_click_classifier;
    import bcc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED      = 2'd3;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         RX_STALL_CYCLES = 300;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd   = CMD_SCAN;
    logic        s_level = 1'b1;
    logic [15:0] s_now   = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_event_res;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    int          mismatch_count;
    int          events_pending;
    int          items_sent  = 0;
    int          quiet_cycles = 0;
    logic [15:0] tick        = '0;
    bit          tx_quiet    = 1'b0;
    bit          rx_quiet    = 1'b0;
    bit          stall_req   = 1'b0;
    int          deb_ms;
    int          long_ms;
    int          combo_ms;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    button_click_classifier dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_level     (s_level),
        .s_now       (s_now),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_event_res (m_event_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    click_event_checker event_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_level        (s_level),
        .s_now          (s_now),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_res    (m_event_res),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .mismatch_count (mismatch_count),
        .events_pending (events_pending)
    );

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (stall_req) begin
                stall_req = 1'b0;
                m_ready <= 1'b0;
                repeat (RX_STALL_CYCLES) @(negedge aclk);
                m_ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (rx_quiet) begin
                m_ready <= 1'b1;
            end else begin
                hold = pick_gap();
                m_ready <= (hold == 0);
                if (hold > 0) begin
                    hold--;
                end
            end
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic lvl, input logic [15:0] now);
        int gap;
        gap = tx_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_level <= lvl;
        s_now   <= now;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    task automatic scan_sample(input logic lvl, input int dt);
        tick = tick + 16'(dt);
        send_item(CMD_SCAN, lvl, tick);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (events_pending == 0);
    endtask

    task automatic set_config(input logic en, input int deb, input int lp, input int cw);
        drain();
        apb_write(REG_SCAN_ENABLE, {31'd0, en});
        apb_write(REG_DEBOUNCE_MS, 32'(deb));
        apb_write(REG_LONG_PRESS_MS, 32'(lp));
        apb_write(REG_COMBO_GAP_MS, 32'(cw));
        deb_ms   = deb;
        long_ms  = lp;
        combo_ms = cw;
    endtask

    // pin chatter shorter than the debounce time, ending on lvl
    task automatic chatter(input logic lvl);
        repeat ($urandom_range(0, 3)) begin
            scan_sample(!lvl, $urandom_range(0, deb_ms / 2));
            scan_sample(lvl, $urandom_range(0, deb_ms / 2));
        end
    endtask

    function automatic int near(input int x);
        int v;
        v = x + $urandom_range(0, 4) - 1;
        if ($urandom_range(0, 1)) begin
            v = x;
        end
        return (v < 0) ? 0 : v;
    endfunction

    task automatic hold_level(input logic lvl, input int ms);
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
            scan_sample(lvl, (i == n - 1) ? ms - (n - 1) * (ms / n) : ms / n);
        end
    endtask

    task automatic press_and_release(input int hold_ms, input int gap_ms);
        chatter(1'b0);
        scan_sample(1'b0, 1);
        scan_sample(1'b0, near(deb_ms));
        hold_level(1'b0, hold_ms);
        chatter(1'b1);
        scan_sample(1'b1, 1);
        scan_sample(1'b1, near(deb_ms));
        hold_level(1'b1, gap_ms);
    endtask

    task automatic gesture();
        int         r;
        int         n;
        logic [1:0] cmd;
        logic       lvl;
        if ($urandom_range(0, 9) == 0) begin
            tx_quiet = !tx_quiet;
        end
        if ($urandom_range(0, 9) == 0) begin
            rx_quiet = !rx_quiet;
        end
        r = $urandom_range(0, 99);
        if (r < 45) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                press_and_release($urandom_range(0, combo_ms / 4),
                                  (i == n - 1) ? combo_ms + $urandom_range(0, combo_ms / 2 + 2)
                                               : $urandom_range(0, combo_ms / 4));
            end
        end else if (r < 62) begin
            press_and_release(long_ms + $urandom_range(0, 20), combo_ms + $urandom_range(1, 20));
        end else if (r < 77) begin
            repeat ($urandom_range(1, 6)) begin
                tick = tick + 16'($urandom_range(0, 2 * deb_ms + 2));
                send_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), tick);
            end
        end else if (r < 87) begin
            cmd = $urandom_range(0, 1) ? CMD_WAKE : CMD_POWER_ON;
            lvl = 1'($urandom_range(0, 1));
            tick = tick + 16'($urandom_range(0, 50));
            send_item(cmd, lvl, tick);
            if (lvl == 1'b0) begin
                hold_level(1'b0, $urandom_range(0, long_ms + 20));
                scan_sample(1'b1, 1);
                scan_sample(1'b1, near(deb_ms));
                hold_level(1'b1, combo_ms + 2);
            end
        end else begin
            // long jumps of the tick, wrapping included
            scan_sample(1'($urandom_range(0, 1)),
                        $urandom_range(0, 1) ? 65535 : $urandom_range(0, 65535));
        end
    endtask

    task automatic run_phase(input logic en, input int deb, input int lp, input int cw,
                             input int count);
        int target;
        set_config(en, deb, lp, cw);
        target = items_sent + count;
        while (items_sent < target) begin
            gesture();
        end
    endtask

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // scanning still disabled after reset
        deb_ms   = DEBOUNCE_RST;
        long_ms  = LONG_PRESS_RST;
        combo_ms = COMBO_GAP_RST;
        send_item(CMD_SCAN, 1'b0, 16'hFFFF);
        send_item(CMD_UNUSED, 1'b0, 16'h0000);
        send_item(CMD_WAKE, 1'b0, 16'h0000);
        send_item(CMD_POWER_ON, 1'b0, 16'hFFFF);
        send_item(CMD_WAKE, 1'b1, 16'h8000);

        set_config(1'b1, 2, 20, 10);
        tick = 16'hFFF0;
        press_and_release(3, 12);
        // held button at power-on, its release counts no click
        send_item(CMD_POWER_ON, 1'b0, tick);
        scan_sample(1'b0, 25);
        scan_sample(1'b1, 1);
        scan_sample(1'b1, 2);
        scan_sample(1'b1, 15);
        // held at wake, long press reported
        send_item(CMD_WAKE, 1'b0, tick);
        scan_sample(1'b0, 20);
        scan_sample(1'b1, 0);
        scan_sample(1'b1, 2);

        // receiver holds off while items keep coming
        stall_req = 1'b1;
        tx_quiet  = 1'b1;
        press_and_release(3, 12);

        run_phase(1'b1, 3, 60, 40, 400);
        run_phase(1'b1, 0, 0, 0, 200);
        run_phase(1'b1, 65535, 65535, 65535, 120);
        run_phase(1'b0, 5, 30, 20, 150);
        repeat (3) begin
            run_phase(1'b1, $urandom_range(0, 8), $urandom_range(30, 120),
                      $urandom_range(30, 60), 250);
        end
        run_phase(1'b1, DEBOUNCE_RST, LONG_PRESS_RST, COMBO_GAP_RST, 200);

        drain();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
